// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int DEQ_CAPACITY = 16;
   localparam int DEQ_IDX_W    = $clog2(DEQ_CAPACITY);
   localparam int DEQ_CNT_W    = $clog2(DEQ_CAPACITY + 1);
   localparam int DEQ_DATA_W   = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_LIST       = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } deq_state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } deq_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic signed [31:0]    element;
      logic                  is_last;
      logic [DEQ_CNT_W-1:0]  fill_count;
   } deq_rsp_type;

endpackage

// ===== hw/rtl/deq_ram.sv =====
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Channel  | Ports                      | Handshake
// request  | start, busy, req_item      | taken when start is high and busy is low
// response | rsp_strobe, rsp_item       | valid for one cycle, cannot be stalled
//
// Push, pop and list of an empty queue keep busy low, and the response shows up the
// cycle after the request.
// List of a non-empty queue holds busy high while it reads every stored entry through the
// single RAM read port and the shared position adder; responses follow one per cycle,
// the first once the state has moved to ST_LIST and the RAM read register is loaded.
// Reset is synchronous and empties the queue; the receiver cannot stall.
module double_ended_queue_top
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  deq_req_type req_item,
   output logic        rsp_strobe,
   output deq_rsp_type rsp_item
);

   localparam int SUM_W = DEQ_CNT_W + 1;

   deq_state_type          state_ff, state_in;
   logic [DEQ_IDX_W-1:0]   head_ff, head_in;
   logic [DEQ_CNT_W-1:0]   count_ff, count_in;
   logic [DEQ_IDX_W-1:0]   idx_ff, idx_in;
   logic                   single_valid_ff, single_valid_in;
   deq_rsp_type            single_rsp_ff, single_rsp_in;
   logic                   list_valid_ff, list_valid_in;
   logic                   list_last_ff, list_last_in;

   logic                   accept;
   logic [DEQ_CNT_W-1:0]   offset;
   logic [SUM_W-1:0]       pos_sum;
   logic [DEQ_IDX_W-1:0]   pos;
   logic                   wr_en;
   logic                   rd_en;
   logic [DEQ_DATA_W-1:0]  rd_data;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Shared position unit: head plus offset, wrapped once around the ring
   always_comb begin
      if (state_ff == ST_LIST) begin
         offset = DEQ_CNT_W'(idx_ff);
      end else if (req_item.opcode == OP_PUSH_FRONT) begin
         offset = DEQ_CNT_W'(DEQ_CAPACITY - 1);
      end else begin
         offset = count_ff;
      end
      pos_sum = SUM_W'(head_ff) + SUM_W'(offset);
      if (pos_sum >= SUM_W'(DEQ_CAPACITY)) begin
         pos = pos_sum[DEQ_IDX_W-1:0] - DEQ_IDX_W'(DEQ_CAPACITY);
      end else begin
         pos = pos_sum[DEQ_IDX_W-1:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      single_valid_in = 1'b0;
      single_rsp_in   = single_rsp_ff;
      list_valid_in   = 1'b0;
      list_last_in    = 1'b0;
      wr_en           = 1'b0;
      rd_en           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               single_valid_in          = 1'b1;
               single_rsp_in.status     = STATUS_OK;
               single_rsp_in.element    = '0;
               single_rsp_in.is_last    = 1'b1;
               case (req_item.opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (count_ff == DEQ_CNT_W'(DEQ_CAPACITY)) begin
                        single_rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (req_item.opcode == OP_PUSH_FRONT) begin
                           head_in = pos;
                        end
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (count_ff == '0) begin
                        single_rsp_in.status = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req_item.opcode == OP_POP_FRONT) begin
                           if (head_ff == DEQ_IDX_W'(DEQ_CAPACITY - 1)) begin
                              head_in = '0;
                           end else begin
                              head_in = head_ff + 1'b1;
                           end
                        end
                     end
                  end
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        single_rsp_in.status = STATUS_EMPTY;
                     end else begin
                        single_valid_in = 1'b0;
                        idx_in          = '0;
                        state_in        = ST_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
               single_rsp_in.fill_count = count_in;
            end
         end
         ST_LIST: begin
            // Issue one read per cycle, front to back
            rd_en         = 1'b1;
            list_valid_in = 1'b1;
            idx_in        = idx_ff + 1'b1;
            if (DEQ_CNT_W'(idx_ff) + 1'b1 == count_ff) begin
               list_last_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         head_ff         <= '0;
         count_ff        <= '0;
         idx_ff          <= '0;
         single_valid_ff <= 1'b0;
         list_valid_ff   <= 1'b0;
         list_last_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         head_ff         <= head_in;
         count_ff        <= count_in;
         idx_ff          <= idx_in;
         single_valid_ff <= single_valid_in;
         list_valid_ff   <= list_valid_in;
         list_last_ff    <= list_last_in;
      end
   end

   always_ff @(posedge clock) begin
      single_rsp_ff <= single_rsp_in;
   end

   deq_ram #(
      .WIDTH (DEQ_DATA_W),
      .DEPTH (DEQ_CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos),
      .wr_data (req_item.value),
      .rd_en   (rd_en),
      .rd_addr (pos),
      .rd_data (rd_data)
   );

   assign rsp_strobe = single_valid_ff || list_valid_ff;

   always_comb begin
      if (list_valid_ff) begin
         rsp_item.status     = STATUS_OK;
         rsp_item.element    = rd_data;
         rsp_item.is_last    = list_last_ff;
         rsp_item.fill_count = count_ff;
      end else begin
         rsp_item = single_rsp_ff;
      end
   end

endmodule

// ===== tb/deq_checker.sv =====
`timescale 1ns / 1ps
module deq_checker
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  deq_req_type req_item,
   input  logic        rsp_strobe,
   input  deq_rsp_type rsp_item,
   output int          fail_count,
   output int          pending
);

   localparam int MAX_PRINTED = 100;

   logic signed [DEQ_DATA_W-1:0] shadow_store [DEQ_CAPACITY];
   int                           shadow_head = 0;
   logic [DEQ_CNT_W-1:0]         shadow_count = '0;
   deq_rsp_type                  awaited_rsp [$];
   int                           errors = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (errors < MAX_PRINTED) begin
         $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      end
      errors++;
   endtask

   // Update the shadow deque for one request and queue the responses it causes.
   task automatic apply_operation(input deq_req_type r);
      deq_rsp_type rsp;
      int          pos;
      rsp = '{status: STATUS_OK, element: '0, is_last: 1'b1, fill_count: '0};
      case (r.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count == DEQ_CAPACITY) begin
               rsp.status = STATUS_FULL;
            end else if (r.opcode == OP_PUSH_FRONT) begin
               shadow_head = (shadow_head + DEQ_CAPACITY - 1) % DEQ_CAPACITY;
               shadow_store[shadow_head] = r.value;
               shadow_count++;
            end else begin
               shadow_store[(shadow_head + shadow_count) % DEQ_CAPACITY] = r.value;
               shadow_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               if (r.opcode == OP_POP_FRONT) begin
                  shadow_head = (shadow_head + 1) % DEQ_CAPACITY;
               end
               shadow_count--;
            end
         end
         OP_LIST: begin
            if (shadow_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               // one response per stored entry, front to back
               for (int i = 0; i < shadow_count; i++) begin
                  pos = (shadow_head + i) % DEQ_CAPACITY;
                  rsp.element = shadow_store[pos];
                  rsp.is_last = (i + 1 == shadow_count);
                  rsp.fill_count = shadow_count;
                  awaited_rsp.push_back(rsp);
               end
               return;
            end
         end
         default: ;
      endcase
      rsp.fill_count = shadow_count;
      awaited_rsp.push_back(rsp);
   endtask

   always @(posedge clock) begin
      deq_rsp_type want;
      if (!reset) begin
         // compare before predicting: a response never belongs to this edge's request
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_item, '0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch("status", rsp_item.status, want.status);
               if (rsp_item.element !== want.element)
                  report_mismatch("element", rsp_item.element, want.element);
               if (rsp_item.is_last !== want.is_last)
                  report_mismatch("is_last", rsp_item.is_last, want.is_last);
               if (rsp_item.fill_count !== want.fill_count)
                  report_mismatch("fill_count", rsp_item.fill_count, want.fill_count);
            end
         end
         if (start && !busy) begin
            apply_operation(req_item);
         end
      end
      fail_count <= errors;
      pending <= awaited_rsp.size();
   end

endmodule

// ===== tb/tb_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
module tb_double_ended_queue_top;
   import deq_pkg::*;

   localparam int         CYCLE_LIMIT      = 200000;
   localparam int         RANDOM_PER_PHASE = 170;
   localparam int         TAIL_CYCLES      = 2 * DEQ_CAPACITY + 4;
   localparam logic [2:0] OP_SPARE_FIRST   = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST    = 3'd7;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        rsp_strobe;
   deq_req_type req_item;
   deq_rsp_type rsp_item;
   int          fail_count;
   int          pending;
   int          cycles = 0;
   int          requests_sent = 0;
   int          idle_pct [3] = '{0, 54, 15};

   double_ended_queue_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   deq_checker deq_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_double_ended_queue_top failed");
         $finish;
      end
   end

   // Hold the request until it is taken; start stays high for a follow-on request.
   task automatic issue(input logic [2:0] op, input logic signed [31:0] val);
      start <= 1'b1;
      req_item <= '{opcode: op, value: val};
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
   endtask

   task automatic idle(input int pct);
      int n;
      if ($urandom_range(99) < pct) begin
         n = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop start and wait for every awaited response.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] any_value();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] weighted_opcode();
      int r;
      r = $urandom_range(99);
      if (r < 22) return OP_PUSH_FRONT;
      if (r < 44) return OP_PUSH_BACK;
      if (r < 62) return OP_POP_FRONT;
      if (r < 80) return OP_POP_BACK;
      if (r < 94) return OP_LIST;
      return OP_SPARE_FIRST + 3'($urandom_range(OP_SPARE_LAST - OP_SPARE_FIRST));
   endfunction

   task automatic random_burst(input int pct);
      case ($urandom_range(9))
         0: begin
            // fill past capacity from any level, then list the full queue
            repeat (DEQ_CAPACITY + 2) begin
               issue($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, any_value());
               idle(pct);
            end
            issue(OP_LIST, any_value());
            idle(pct);
         end
         1: begin
            repeat (DEQ_CAPACITY + 2) begin
               issue($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, any_value());
               idle(pct);
            end
         end
         2: begin
            issue(3'($urandom_range(7)), any_value());
            idle(pct);
         end
         default: begin
            issue(weighted_opcode(), any_value());
            idle(pct);
         end
      endcase
   endtask

   initial begin
      int directed_sent;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: list, both pops, unused opcodes
      issue(OP_LIST, 32'sd5);
      issue(OP_POP_FRONT, '0);
      issue(OP_POP_BACK, -32'sd1);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         issue(3'(op), 32'sh7fff_ffff);
      end
      // push front from head zero wraps the head index
      issue(OP_PUSH_FRONT, 32'sh8000_0000);
      issue(OP_PUSH_BACK, 32'sh7fff_ffff);
      issue(OP_PUSH_FRONT, '0);
      issue(OP_PUSH_BACK, -32'sd1);
      issue(OP_LIST, '0);
      issue(OP_SPARE_LAST, 32'sh5a5a_a5a5);
      issue(OP_POP_FRONT, '0);
      issue(OP_POP_BACK, '0);
      issue(OP_LIST, '0);
      issue(OP_POP_BACK, '0);
      issue(OP_POP_FRONT, '0);
      issue(OP_LIST, '0);
      issue(OP_POP_FRONT, '0);
      settle();
      directed_sent = requests_sent;

      for (int phase = 0; phase < 3; phase++) begin
         while (requests_sent < directed_sent + (phase + 1) * RANDOM_PER_PHASE) begin
            random_burst(idle_pct[phase]);
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_double_ended_queue_top passed");
      end else begin
         $display("tb_double_ended_queue_top failed");
      end
      $finish;
   end

endmodule
